@@ hw/rtl/akf_pkg.sv @@
// Shared types, constants and saturation helpers for the angle Kalman filter.
package akf_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int COV_FRAC_BITS   = 24;
  localparam int DT_FRAC_BITS    = 16;
  localparam int GAIN_FRAC_BITS  = 30;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int NUM_W   = 32 + GAIN_FRAC_BITS;
  localparam int DEN_W   = 34;
  localparam int ACC_W   = 40;

  localparam logic [31:0] ANG_NOISE_RST  = 32'd16777;
  localparam logic [31:0] BIAS_NOISE_RST = 32'd50332;
  localparam logic [31:0] MEAS_NOISE_RST = 32'd503316;

  typedef enum logic [1:0] {
    CFG_ANGLE_NOISE = 2'd0,
    CFG_BIAS_NOISE  = 2'd1,
    CFG_MEAS_NOISE  = 2'd2
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_M_ANG,
    ST_M_P11,
    ST_INNER,
    ST_M_P00,
    ST_M_QB,
    ST_S,
    ST_DIV0_GO,
    ST_DIV0_WAIT,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_M_K0Y,
    ST_M_K1Y,
    ST_M_K0P00,
    ST_M_K0P01,
    ST_M_K1P00,
    ST_M_K1P01,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    return (v > ACC_W'(64'sd2147483647)) || (v < -ACC_W'(64'sd2147483648));
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(64'sd2147483647)) begin
      return 32'sh7fffffff;
    end else if (v < -ACC_W'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/akf_mul.sv @@
// Shared registered signed multiplier.
module akf_mul (
  input  logic                            clk,
  input  logic signed [akf_pkg::MUL_A_W-1:0] a,
  input  logic signed [akf_pkg::MUL_B_W-1:0] b,
  output logic signed [akf_pkg::PROD_W-1:0]  prod
);
  import akf_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ hw/rtl/akf_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module akf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  akf_pkg::div_req_t         req,
  output logic                      done,
  output logic [akf_pkg::NUM_W-1:0] quo
);
  import akf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den <= req.den;
      rem <= '0;
      quo <= req.num;
    end else if (run) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

@@ hw/rtl/angle_kalman_filter_core.sv @@
// Top level of the two-state angle and gyro bias Kalman filter.
// Input channel: in_valid/in_ready with measured_angle, gyro_rate, time_step.
// Output channel: out_valid/out_ready with angle_estimate, corrected_rate,
// bias_estimate and saturated; one result per input transaction.
// Config channel: cfg_valid/cfg_ready, cfg_index 0..2 selects the noise
// register, other indexes are ignored; cfg_ready is always high.
// Each transaction runs through the sequencer steps in turn: two restoring
// divisions for the gains (62 quotient bits each) dominate, and the other
// steps share one registered multiplier. With a zero innovation variance
// the divisions are skipped. in_ready is high only while the sequencer is
// idle, so a new transaction is accepted only after the previous one has
// left the sequencer.
// The result sits in an output register; the next input is accepted while it
// waits. If the receiver stalls, a finished update holds in its last step
// until the output register is free.
// Reset (rst, synchronous) clears angle, bias and covariance to zero and
// loads the default noise registers.
module angle_kalman_filter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] gyro_rate,
  input  logic        [15:0] time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] angle_estimate,
  output logic signed [31:0] corrected_rate,
  output logic signed [31:0] bias_estimate,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic         [1:0] cfg_index,
  input  logic        [31:0] cfg_data
);
  import akf_pkg::*;

  state_t state, state_next;

  logic [31:0] q_ang, q_bias, r_meas;
  logic signed [31:0] angle_state, bias_state;
  logic signed [31:0] cov00, cov01, cov10, cov11;

  logic signed [31:0] meas, gyro;
  logic        [15:0] dt;
  logic signed [31:0] rate, ang, p00, p01, p10, p11, y, k0, k1;
  logic signed [31:0] dtp11;
  logic signed [MUL_A_W-1:0] inner;
  logic signed [DEN_W-1:0]   s;
  logic sat;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   sh_dt, sh_gain;

  div_req_t         div_req;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic signed [32:0] p_div;
  logic [32:0]        p_mag;
  logic               p_neg;

  logic signed [ACC_W-1:0] t_rate, t_ang, t_p00, t_p01, t_p10, t_p11, t_y;
  logic signed [ACC_W-1:0] t_gain;
  logic signed [ACC_W-1:0] t_base;
  logic signed [MUL_A_W-1:0] t_inner;

  logic               out_free;
  logic               g_ovf;
  logic signed [31:0] g_val;

  akf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  akf_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quo(div_quo));

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign sh_dt   = ACC_W'(prod >>> DT_FRAC_BITS);
  assign sh_gain = ACC_W'(prod >>> GAIN_FRAC_BITS);

  assign t_rate  = ACC_W'(gyro) - ACC_W'(bias_state);
  assign t_ang   = ACC_W'(angle_state) + sh_dt;
  assign t_inner = MUL_A_W'(sh_dt) - MUL_A_W'(cov01) - MUL_A_W'(cov10)
                 + MUL_A_W'({1'b0, q_ang});
  assign t_p00   = ACC_W'(cov00) + sh_dt;
  assign t_p01   = ACC_W'(cov01) - ACC_W'(dtp11);
  assign t_p10   = ACC_W'(cov10) - ACC_W'(dtp11);
  assign t_p11   = ACC_W'(cov11) + sh_dt;
  assign t_y     = ACC_W'(meas) - ACC_W'(ang);

  always_comb begin
    case (state)
      ST_M_K1Y:   t_base = ACC_W'(ang);
      ST_M_K0P00: t_base = ACC_W'(bias_state);
      default:    t_base = '0;
    endcase
  end

  always_comb begin
    t_gain = t_base + sh_gain;
    case (state)
      ST_M_K0P01: t_gain = ACC_W'(p00) - sh_gain;
      ST_M_K1P00: t_gain = ACC_W'(p01) - sh_gain;
      ST_M_K1P01: t_gain = ACC_W'(p10) - sh_gain;
      ST_FIN:     t_gain = ACC_W'(p11) - sh_gain;
      default:    ;
    endcase
  end

  // divider operands: |P| << 30 over |S|
  assign p_div = (state == ST_DIV1_GO || state == ST_DIV1_WAIT) ? 33'(p10) : 33'(p00);
  assign p_neg = p_div[32] ^ s[DEN_W-1];
  assign p_mag = p_div[32] ? 33'(-p_div) : p_div;

  always_comb begin
    div_req.start = (state == ST_DIV0_GO && s != '0) || (state == ST_DIV1_GO);
    div_req.num   = NUM_W'({p_mag, GAIN_FRAC_BITS'(0)});
    div_req.den   = s[DEN_W-1] ? DEN_W'(-s) : s;
  end

  always_comb begin
    if (p_neg) begin
      g_ovf = div_quo > NUM_W'(64'h80000000);
      g_val = g_ovf ? 32'sh80000000 : 32'(-div_quo[31:0]);
    end else begin
      g_ovf = div_quo > NUM_W'(64'h7fffffff);
      g_val = g_ovf ? 32'sh7fffffff : div_quo[31:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = MUL_B_W'({1'b0, dt});
    case (state)
      ST_M_ANG:   mul_a = MUL_A_W'(rate);
      ST_M_P11:   mul_a = MUL_A_W'(cov11);
      ST_M_P00:   mul_a = inner;
      ST_M_QB:    mul_a = MUL_A_W'({1'b0, q_bias});
      ST_M_K0Y:   begin mul_a = MUL_A_W'(k0); mul_b = MUL_B_W'(y);   end
      ST_M_K1Y:   begin mul_a = MUL_A_W'(k1); mul_b = MUL_B_W'(y);   end
      ST_M_K0P00: begin mul_a = MUL_A_W'(k0); mul_b = MUL_B_W'(p00); end
      ST_M_K0P01: begin mul_a = MUL_A_W'(k0); mul_b = MUL_B_W'(p01); end
      ST_M_K1P00: begin mul_a = MUL_A_W'(k1); mul_b = MUL_B_W'(p00); end
      ST_M_K1P01, ST_FIN: begin mul_a = MUL_A_W'(k1); mul_b = MUL_B_W'(p01); end
      default:    ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_RATE;
      ST_RATE:      state_next = ST_M_ANG;
      ST_M_ANG:     state_next = ST_M_P11;
      ST_M_P11:     state_next = ST_INNER;
      ST_INNER:     state_next = ST_M_P00;
      ST_M_P00:     state_next = ST_M_QB;
      ST_M_QB:      state_next = ST_S;
      ST_S:         state_next = ST_DIV0_GO;
      ST_DIV0_GO:   state_next = (s == '0) ? ST_M_K0Y : ST_DIV0_WAIT;
      ST_DIV0_WAIT: if (div_done) state_next = ST_DIV1_GO;
      ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
      ST_DIV1_WAIT: if (div_done) state_next = ST_M_K0Y;
      ST_M_K0Y:     state_next = ST_M_K1Y;
      ST_M_K1Y:     state_next = ST_M_K0P00;
      ST_M_K0P00:   state_next = ST_M_K0P01;
      ST_M_K0P01:   state_next = ST_M_K1P00;
      ST_M_K1P00:   state_next = ST_M_K1P01;
      ST_M_K1P01:   state_next = ST_FIN;
      ST_FIN:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ang  <= ANG_NOISE_RST;
      q_bias <= BIAS_NOISE_RST;
      r_meas <= MEAS_NOISE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ANGLE_NOISE: q_ang  <= cfg_data;
        CFG_BIAS_NOISE:  q_bias <= cfg_data;
        CFG_MEAS_NOISE:  r_meas <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      angle_estimate <= angle_state;
      corrected_rate <= rate;
      bias_estimate  <= bias_state;
      saturated      <= sat || ovf32(t_gain);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_state <= '0;
      bias_state  <= '0;
      cov00       <= '0;
      cov01       <= '0;
      cov10       <= '0;
      cov11       <= '0;
    end else begin
      case (state)
        ST_M_K1Y:   angle_state <= clamp32(t_gain);
        ST_M_K0P00: bias_state  <= clamp32(t_gain);
        ST_M_K0P01: cov00       <= clamp32(t_gain);
        ST_M_K1P00: cov01       <= clamp32(t_gain);
        ST_M_K1P01: cov10       <= clamp32(t_gain);
        ST_FIN:     if (out_free) cov11 <= clamp32(t_gain);
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        meas <= measured_angle;
        gyro <= gyro_rate;
        dt   <= time_step;
        sat  <= 1'b0;
      end
      ST_RATE: begin
        rate <= clamp32(t_rate);
        sat  <= ovf32(t_rate);
      end
      ST_M_P11: begin
        ang <= clamp32(t_ang);
        sat <= sat || ovf32(t_ang);
      end
      ST_INNER: begin
        dtp11 <= sh_dt[31:0];
        inner <= t_inner;
      end
      ST_M_P00: begin
        p01   <= clamp32(t_p01);
        p10   <= clamp32(t_p10);
        sat   <= sat || ovf32(t_p01) || ovf32(t_p10);
      end
      ST_M_QB: begin
        p00 <= clamp32(t_p00);
        sat <= sat || ovf32(t_p00);
      end
      ST_S: begin
        p11 <= clamp32(t_p11);
        s   <= DEN_W'(p00) + DEN_W'({1'b0, r_meas});
        y   <= clamp32(t_y);
        sat <= sat || ovf32(t_p11) || ovf32(t_y);
      end
      ST_DIV0_GO: begin
        if (s == '0) begin
          k0  <= '0;
          k1  <= '0;
          sat <= 1'b1;
        end
      end
      ST_DIV0_WAIT: begin
        if (div_done) begin
          k0  <= g_val;
          sat <= sat || g_ovf;
        end
      end
      ST_DIV1_WAIT: begin
        if (div_done) begin
          k1  <= g_val;
          sat <= sat || g_ovf;
        end
      end
      ST_M_K1Y, ST_M_K0P00, ST_M_K0P01, ST_M_K1P00, ST_M_K1P01: begin
        sat <= sat || ovf32(t_gain);
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_RATE))
    else $error("accepted transaction did not start the sequencer");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (s != '0))
    else $error("division started with zero divisor");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV0_WAIT || state == ST_DIV1_WAIT))
    else $error("divider finished outside a wait step");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !out_free) |=> (state == ST_FIN) && out_valid)
    else $error("result dropped while receiver stalled");
`endif

endmodule
